// ----- design/oate_pkg.sv -----
// ----------------------------------------------------------------------------
// oate_pkg
// Shared types and constants for the ordered array table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package oate_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned STAT_W    = 3;

  typedef enum logic [1:0] {
    OP_DISPLAY = 2'd0,
    OP_INSERT  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_SEARCH  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BADPOS   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SWEEP = 1'b1
  } state_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   cnt;
    logic [DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/oate_cell.sv -----
// ----------------------------------------------------------------------------
// oate_cell
// One entry of the table; takes its left or right neighbour on edits and
// rotations.
// ----------------------------------------------------------------------------
`default_nettype none

module oate_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire                              clk_i,
  input  wire oate_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic signed [oate_pkg::DATA_W-1:0] left_i,
  input  wire logic signed [oate_pkg::DATA_W-1:0] right_i,
  input  wire logic signed [oate_pkg::DATA_W-1:0] wrap_i,
  output logic signed [oate_pkg::DATA_W-1:0]      data_o
);
  import oate_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic [CNT_W-1:0]         my_idx;

  assign my_idx = CNT_W'(IDX);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      CELL_INS: begin
        if (my_idx > ctrl_i.pos) begin
          data_d = left_i;
        end else if (my_idx == ctrl_i.pos) begin
          data_d = ctrl_i.value;
        end
      end
      CELL_DEL: begin
        if (my_idx >= ctrl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROT: begin
        // last valid cell closes the ring back to cell 0
        if (my_idx == ctrl_i.cnt - CNT_W'(1)) begin
          data_d = wrap_i;
        end else if (my_idx < ctrl_i.cnt - CNT_W'(1)) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- design/ordered_array_table_engine_unit.sv -----
// ----------------------------------------------------------------------------
// ordered_array_table_engine_unit
// Ordered table of signed entries held in a row of cells, with insert,
// delete, linear search and display.
// ----------------------------------------------------------------------------
// Insert, delete, and display/search of an empty table: result in the cycle after
// the transfer, a new item may follow in the very next cycle.
// Display and search rotate the ring of cells past cell 0, one entry a cycle:
// busy for the whole sweep; display results, registered from cell 0, come on
// consecutive cycles, the search result registered after the last entry.
// Asynchronous active-low reset empties the table; the receiver cannot stall.
`default_nettype none

module ordered_array_table_engine_unit #(
  parameter int unsigned DEPTH = oate_pkg::DEPTH_DEF
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     start_i,
  output logic                                    busy_o,
  input  wire logic [1:0]                         op_i,
  input  wire logic signed [oate_pkg::DATA_W-1:0] value_i,
  input  wire logic [oate_pkg::POS_W-1:0]         position_i,
  output logic                                    result_valid_o,
  output logic [oate_pkg::STAT_W-1:0]             status_o,
  output logic signed [oate_pkg::DATA_W-1:0]      element_o,
  output logic [oate_pkg::IDX_W-1:0]              index_o,
  output logic                                    last_o
);
  import oate_pkg::*;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         k_q, k_d;
  op_e                      sop_q, sop_d;
  logic signed [DATA_W-1:0] key_q, key_d;
  logic                     found_q, found_d;
  logic [IDX_W-1:0]         fidx_q, fidx_d;

  logic                     rv_q, rv_d;
  status_e                  st_q, st_d;
  logic signed [DATA_W-1:0] el_q, el_d;
  logic [IDX_W-1:0]         ix_q, ix_d;
  logic                     last_q, last_d;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] data_w [DEPTH];
  logic signed [DATA_W-1:0] front;
  logic                     at_end;
  logic                     hit;
  op_e                      op;

  assign op    = op_e'(op_i);
  assign front = data_w[0];

  // ring of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid
      assign left_w = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = data_w[g];
    end else begin : g_inner
      assign right_w = data_w[g+1];
    end
    oate_cell #(.IDX(g)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .wrap_i  (front),
      .data_o  (data_w[g])
    );
  end

  assign at_end = ({1'b0, k_q} == count_q - CNT_W'(1));
  assign hit    = (front == key_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    k_d     = k_q;
    sop_d   = sop_q;
    key_d   = key_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    rv_d    = 1'b0;
    st_d    = STAT_OK;
    el_d    = '0;
    ix_d    = '0;
    last_d  = 1'b0;
    ctrl.cmd   = CELL_HOLD;
    ctrl.pos   = position_i;
    ctrl.cnt   = count_q;
    ctrl.value = value_i;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (op)
            OP_DISPLAY, OP_SEARCH: begin
              if (count_q == '0) begin
                rv_d   = 1'b1;
                last_d = 1'b1;
                st_d   = (op == OP_DISPLAY) ? STAT_EMPTY : STAT_NOTFOUND;
              end else begin
                state_d = ST_SWEEP;
                k_d     = '0;
                found_d = 1'b0;
                sop_d   = op;
                key_d   = value_i;
              end
            end
            OP_INSERT: begin
              rv_d   = 1'b1;
              last_d = 1'b1;
              if (position_i > count_q) begin
                st_d = STAT_BADPOS;
              end else if (count_q == CNT_W'(DEPTH)) begin
                st_d = STAT_FULL;
              end else begin
                ctrl.cmd = CELL_INS;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              rv_d   = 1'b1;
              last_d = 1'b1;
              if (position_i >= count_q) begin
                st_d = STAT_BADPOS;
              end else begin
                ctrl.cmd = CELL_DEL;
                count_d  = count_q - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SWEEP: begin
        ctrl.cmd = CELL_ROT;
        if (sop_q == OP_DISPLAY) begin
          rv_d   = 1'b1;
          el_d   = front;
          ix_d   = k_q;
          last_d = at_end;
        end else begin
          if (!found_q && hit) begin
            found_d = 1'b1;
            fidx_d  = k_q;
          end
          if (at_end) begin
            rv_d   = 1'b1;
            last_d = 1'b1;
            if (found_q || hit) begin
              st_d = STAT_OK;
              ix_d = found_q ? fidx_q : k_q;
            end else begin
              st_d = STAT_NOTFOUND;
            end
          end
        end
        if (at_end) begin
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      found_q <= found_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sop_q  <= sop_d;
    key_q  <= key_d;
    fidx_q <= fidx_d;
    st_q   <= st_d;
    el_q   <= el_d;
    ix_q   <= ix_d;
    last_q <= last_d;
  end

  assign busy_o         = (state_q == ST_SWEEP);
  assign result_valid_o = rv_q;
  assign status_o       = st_q;
  assign element_o      = el_q;
  assign index_o        = ix_q;
  assign last_o         = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count beyond table depth");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> ({1'b0, k_q} < count_q))
    else $error("sweep index beyond count");

  a_sweep_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |=> (count_q == $past(count_q)))
    else $error("count changed during sweep");

  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (op_i == OP_INSERT || op_i == OP_DELETE))
      |=> (result_valid_o && last_o))
    else $error("edit gave no result");

endmodule

`default_nettype wire
